>>> design/aolq_pkg.sv
// shared types, constants and codes for the open list queue
package aolq_pkg;

   localparam int QueueDepth = 64;
   localparam int CoordBits  = 10;
   localparam int CostBits   = 16;
   localparam int TagBits    = 16;
   localparam int IdxBits    = $clog2(QueueDepth);
   localparam int CountBits  = $clog2(QueueDepth + 1);

   localparam logic [1:0] ACT_PUSH   = 2'd0;
   localparam logic [1:0] ACT_POP    = 2'd1;
   localparam logic [1:0] ACT_SEARCH = 2'd2;
   localparam logic [1:0] ACT_NONE   = 2'd3;

   localparam logic [1:0] STS_OK        = 2'd0;
   localparam logic [1:0] STS_POP_EMPTY = 2'd1;
   localparam logic [1:0] STS_FULL      = 2'd2;
   localparam logic [1:0] STS_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic [CoordBits-1:0] coord_x;
      logic [CoordBits-1:0] coord_y;
      logic [CostBits-1:0]  cost_g;
      logic [CostBits-1:0]  cost_h;
      logic [TagBits-1:0]   parent;
   } entry_type;

   typedef struct packed {
      logic [1:0] action;
      entry_type  entry;
   } req_word_type;

   typedef struct packed {
      logic [1:0]           status;
      logic                 found;
      entry_type            entry;
      logic [CountBits-1:0] entry_count;
   } rsp_word_type;

   typedef struct packed {
      logic load;
      logic find;
      logic place;
      logic publish;
   } cmd_type;

   typedef struct packed {
      logic is_push;
   } sts_type;

endpackage

>>> design/aolq_if.sv
// request and response channel interfaces
interface aolq_req_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    action;
   logic [aolq_pkg::CoordBits-1:0] coord_x;
   logic [aolq_pkg::CoordBits-1:0] coord_y;
   logic [aolq_pkg::CostBits-1:0]  cost_g;
   logic [aolq_pkg::CostBits-1:0]  cost_h;
   logic [aolq_pkg::TagBits-1:0]   parent_tag;
   modport source(output valid, action, coord_x, coord_y, cost_g, cost_h, parent_tag,
                  input ready);
   modport sink(input valid, action, coord_x, coord_y, cost_g, cost_h, parent_tag,
                output ready);
endinterface

interface aolq_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [1:0]                     status;
   logic                           found;
   logic [aolq_pkg::CoordBits-1:0] out_x;
   logic [aolq_pkg::CoordBits-1:0] out_y;
   logic [aolq_pkg::CostBits-1:0]  out_g;
   logic [aolq_pkg::CostBits-1:0]  out_h;
   logic [aolq_pkg::TagBits-1:0]   out_parent;
   logic [aolq_pkg::CountBits-1:0] entry_count;
   modport source(output valid, status, found, out_x, out_y, out_g, out_h, out_parent,
                  entry_count, input ready);
   modport sink(input valid, status, found, out_x, out_y, out_g, out_h, out_parent,
                entry_count, output ready);
endinterface

>>> design/astar_open_list_queue_core.sv
// top level of the sorted open list queue with coordinate update
// Open list for a grid path search: up to QueueDepth entries kept sorted by
// g+h, lowest first, equal totals in arrival order. Push replaces any entry
// with the same coordinate, pop returns the front, search returns the entry
// for a coordinate; every response word carries the entry count. One request
// word is in flight at a time: a pop, search or unused code passes the
// match/remove step and then the response register load, a push the
// match/remove step, the insert step in the shift-register cell row and
// then the response register load. A new word is taken as soon as the
// previous one has been handed to the response register, even while that
// word still waits on rsp ready; that hand-over itself waits for the ready.
module astar_open_list_queue_core (
   input logic         clock,
   input logic         reset,
   aolq_req_if.sink    req_chan,
   aolq_rsp_if.source  rsp_chan
);

   aolq_pkg::cmd_type      cmd;
   aolq_pkg::sts_type      sts;
   aolq_pkg::req_word_type req_word;
   aolq_pkg::rsp_word_type rsp_word;

   // pack the request word
   assign req_word.action       = req_chan.action;
   assign req_word.entry.coord_x = req_chan.coord_x;
   assign req_word.entry.coord_y = req_chan.coord_y;
   assign req_word.entry.cost_g  = req_chan.cost_g;
   assign req_word.entry.cost_h  = req_chan.cost_h;
   assign req_word.entry.parent  = req_chan.parent_tag;

   // sequencer
   aolq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // sorted cell row and response register
   aolq_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .sts      (sts),
      .req_word (req_word),
      .rsp_word (rsp_word)
   );

   // unpack the response word
   assign rsp_chan.status      = rsp_word.status;
   assign rsp_chan.found       = rsp_word.found;
   assign rsp_chan.out_x       = rsp_word.entry.coord_x;
   assign rsp_chan.out_y       = rsp_word.entry.coord_y;
   assign rsp_chan.out_g       = rsp_word.entry.cost_g;
   assign rsp_chan.out_h       = rsp_word.entry.cost_h;
   assign rsp_chan.out_parent  = rsp_word.entry.parent;
   assign rsp_chan.entry_count = rsp_word.entry_count;

endmodule

>>> design/aolq_ctrl.sv
// sequencing state machine for the open list queue
module aolq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  aolq_pkg::sts_type sts,
   output aolq_pkg::cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_FIND  = 4'b0010,
      ST_PLACE = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_FIND;
            end
         end
         ST_FIND: begin
            cmd.find = 1'b1;
            state_in = sts.is_push ? ST_PLACE : ST_DONE;
         end
         ST_PLACE: begin
            cmd.place = 1'b1;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef NO_ASSERTIONS
   a_publish_only_done: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> state_ff == ST_DONE)
      else $error("publish outside done state");
   a_place_after_find: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PLACE |-> $past(state_ff) == ST_FIND)
      else $error("place step not preceded by find");
   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE && rsp_valid_ff && !rsp_ready |=> state_ff == ST_DONE)
      else $error("result overwrote an untaken word");
`endif

endmodule

>>> design/aolq_datapath.sv
// sorted shift-register cell row, result and response registers
module aolq_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  aolq_pkg::cmd_type      cmd,
   output aolq_pkg::sts_type      sts,
   input  aolq_pkg::req_word_type req_word,
   output aolq_pkg::rsp_word_type rsp_word
);

   localparam int Depth    = aolq_pkg::QueueDepth;
   localparam int IdxW     = aolq_pkg::IdxBits;
   localparam int CntW     = aolq_pkg::CountBits;
   localparam int EntryW   = $bits(aolq_pkg::entry_type);
   localparam int TotalW   = aolq_pkg::CostBits + 1;

   aolq_pkg::entry_type    cell_ff [Depth];
   aolq_pkg::entry_type    cell_in [Depth];
   aolq_pkg::req_word_type req_ff;
   logic [CntW-1:0]        count_ff, count_in;
   logic [1:0]             status_ff, status_in;
   logic                   found_ff, found_in;
   aolq_pkg::entry_type    res_ff, res_in;
   aolq_pkg::rsp_word_type rsp_ff;

   logic [Depth-1:0]  match_vec;
   logic [Depth-1:0]  above_vec;
   logic              match_any;
   logic [IdxW-1:0]   match_idx;
   logic [EntryW-1:0] hit_bits;
   logic [TotalW-1:0] new_total;
   logic [TotalW-1:0] cell_total;
   logic              do_remove;
   logic [IdxW-1:0]   rm_idx;

   // per-cell compare against the held request
   always_comb begin
      new_total = {1'b0, req_ff.entry.cost_g} + {1'b0, req_ff.entry.cost_h};
      match_idx = '0;
      hit_bits  = '0;
      cell_total = '0;
      for (int i = 0; i < Depth; i++) begin
         cell_total   = {1'b0, cell_ff[i].cost_g} + {1'b0, cell_ff[i].cost_h};
         match_vec[i] = (CntW'(i) < count_ff)
                        && (cell_ff[i].coord_x == req_ff.entry.coord_x)
                        && (cell_ff[i].coord_y == req_ff.entry.coord_y);
         above_vec[i] = (CntW'(i) < count_ff) && (cell_total > new_total);
         if (match_vec[i]) begin
            match_idx = match_idx | IdxW'(i);
            hit_bits  = hit_bits | EntryW'(cell_ff[i]);
         end
      end
      match_any = |match_vec;
   end

   always_comb begin
      do_remove = 1'b0;
      rm_idx    = '0;
      case (req_ff.action)
         aolq_pkg::ACT_PUSH: begin
            do_remove = match_any;
            rm_idx    = match_idx;
         end
         aolq_pkg::ACT_POP: begin
            do_remove = (count_ff != '0);
         end
         default: do_remove = 1'b0;
      endcase
   end

   always_comb begin
      cell_in   = cell_ff;
      count_in  = count_ff;
      status_in = status_ff;
      found_in  = found_ff;
      res_in    = res_ff;
      if (cmd.find) begin
         status_in = aolq_pkg::STS_OK;
         found_in  = 1'b0;
         res_in    = '0;
         case (req_ff.action)
            aolq_pkg::ACT_POP: begin
               if (count_ff == '0) begin
                  status_in = aolq_pkg::STS_POP_EMPTY;
               end else begin
                  found_in = 1'b1;
                  res_in   = cell_ff[0];
               end
            end
            aolq_pkg::ACT_SEARCH: begin
               if (match_any) begin
                  found_in = 1'b1;
                  res_in   = aolq_pkg::entry_type'(hit_bits);
               end else begin
                  status_in = aolq_pkg::STS_NOT_FOUND;
               end
            end
            default: status_in = aolq_pkg::STS_OK;
         endcase
         if (do_remove) begin
            for (int i = 0; i < Depth - 1; i++) begin
               if (IdxW'(i) >= rm_idx) begin
                  cell_in[i] = cell_ff[IdxW'(i + 1)];
               end
            end
            count_in = count_ff - CntW'(1);
         end
      end
      if (cmd.place) begin
         if (count_ff == CntW'(Depth)) begin
            status_in = aolq_pkg::STS_FULL;
         end else begin
            for (int i = 0; i < Depth; i++) begin
               if (i > 0 && above_vec[IdxW'(i - 1)]) begin
                  cell_in[i] = cell_ff[IdxW'(i - 1)];
               end else if (above_vec[i] || CntW'(i) == count_ff) begin
                  cell_in[i] = req_ff.entry;
               end
            end
            count_in = count_ff + CntW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      cell_ff   <= cell_in;
      status_ff <= status_in;
      found_ff  <= found_in;
      res_ff    <= res_in;
      if (cmd.load) begin
         req_ff <= req_word;
      end
      if (cmd.publish) begin
         rsp_ff.status      <= status_ff;
         rsp_ff.found       <= found_ff;
         rsp_ff.entry       <= res_ff;
         rsp_ff.entry_count <= count_ff;
      end
   end

   assign sts.is_push = (req_ff.action == aolq_pkg::ACT_PUSH);
   assign rsp_word    = rsp_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(Depth))
      else $error("entry count above depth");
   a_unique_coord: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match_vec))
      else $error("coordinate stored twice");
   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.place && count_ff != CntW'(Depth) |=> count_ff == $past(count_ff) + CntW'(1))
      else $error("insert did not grow the count");
`endif

endmodule
